// ===== hw/rtl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, codes, state encoding and saturating helpers for the
// step scale calibrator.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int DATA_BITS      = 32;
   localparam int SUM_BITS       = 48;
   localparam int FRAC_BITS      = 16;
   localparam int HUNDRED_BITS   = 7;
   localparam int PROD_BITS      = DATA_BITS + HUNDRED_BITS;
   localparam int AGREE_NUM_BITS = PROD_BITS + FRAC_BITS;
   localparam int AGREE_BITS     = AGREE_NUM_BITS + 2;
   localparam int DIV_NUM_BITS   = SUM_BITS + FRAC_BITS;
   localparam int DIV_DEN_BITS   = SUM_BITS;
   localparam int DIV_STEP_BITS  = 7;
   localparam int CSR_ADDR_BITS  = 4;

   localparam logic [DIV_STEP_BITS-1:0] MEAN_STEPS  = DIV_STEP_BITS'(SUM_BITS);
   localparam logic [DIV_STEP_BITS-1:0] SCALE_STEPS = DIV_STEP_BITS'(DIV_NUM_BITS);
   localparam logic [DIV_STEP_BITS-1:0] AGREE_STEPS = DIV_STEP_BITS'(AGREE_NUM_BITS);

   localparam logic [HUNDRED_BITS-1:0] HUNDRED   = HUNDRED_BITS'(100);
   localparam logic [AGREE_BITS-1:0]   HUNDRED_Q = AGREE_BITS'(6553600);

   localparam logic [SUM_BITS-1:0]  SUM_MAX  = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0]  SUM_MIN  = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic [SUM_BITS-1:0]  USUM_MAX = {SUM_BITS{1'b1}};
   localparam logic [DATA_BITS-1:0] S32_MAX  = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic [DATA_BITS-1:0] S32_MIN  = {1'b1, {(DATA_BITS-1){1'b0}}};
   localparam logic [DATA_BITS-1:0] U32_MAX  = {DATA_BITS{1'b1}};

   // item modes
   localparam logic MODE_REFERENCE = 1'b0;
   localparam logic MODE_SENSOR    = 1'b1;

   // register indexes
   localparam logic [1:0] REG_REJECT_LEVEL   = 2'd0;
   localparam logic [1:0] REG_INITIAL_SCALE  = 2'd1;
   localparam logic [1:0] REG_WORST_ACCURACY = 2'd2;

   localparam logic [DATA_BITS-1:0] REJECT_LEVEL_RESET   = DATA_BITS'(655360);
   localparam logic [DATA_BITS-1:0] INITIAL_SCALE_RESET  = DATA_BITS'(65536);
   localparam logic [DATA_BITS-1:0] WORST_ACCURACY_RESET = U32_MAX;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_RACC_DIV,
      ST_RACC_CHK,
      ST_SACC_DIV,
      ST_SACC_CHK,
      ST_SCALE_DIV,
      ST_AGREE_PREP,
      ST_AGREE_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                     start;
      logic [DIV_NUM_BITS-1:0]  numer;
      logic [DIV_DEN_BITS-1:0]  denom;
      logic [DIV_STEP_BITS-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic [DIV_NUM_BITS-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] reject_level;
      logic [DATA_BITS-1:0] worst_accuracy;
   } cfg_type;

   typedef struct packed {
      logic                 done;
      logic                 updated;
      logic                 fault;
      logic [DATA_BITS-1:0] scale;
      logic [DATA_BITS-1:0] accuracy;
      logic [DATA_BITS-1:0] agreement;
   } cal_result_type;

   function automatic logic [SUM_BITS-1:0] sat_add_sum(input logic [SUM_BITS-1:0]  s,
                                                       input logic [DATA_BITS-1:0] a);
      logic [SUM_BITS:0] t;
      t = {s[SUM_BITS-1], s} + {{(SUM_BITS+1-DATA_BITS){a[DATA_BITS-1]}}, a};
      if (t[SUM_BITS] != t[SUM_BITS-1]) begin
         return t[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end
      return t[SUM_BITS-1:0];
   endfunction

   function automatic logic [SUM_BITS-1:0] sat_add_usum(input logic [SUM_BITS-1:0]  s,
                                                        input logic [DATA_BITS-1:0] a);
      logic [SUM_BITS:0] t;
      t = {1'b0, s} + {{(SUM_BITS+1-DATA_BITS){1'b0}}, a};
      return t[SUM_BITS] ? USUM_MAX : t[SUM_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] inc_count(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + COUNT_BITS'(1);
   endfunction

   function automatic logic [SUM_BITS-1:0] mag_sum(input logic [SUM_BITS-1:0] s);
      return s[SUM_BITS-1] ? (~s + SUM_BITS'(1)) : s;
   endfunction

   function automatic logic [PROD_BITS-1:0] times_hundred(input logic [DATA_BITS-1:0] x);
      return {{HUNDRED_BITS{1'b0}}, x} * {{DATA_BITS{1'b0}}, HUNDRED};
   endfunction

   // mean accuracy: worst when empty or when the sum is zero, otherwise quotient clipped to 32 bits
   function automatic logic [DATA_BITS-1:0] mean_value(input logic [DIV_NUM_BITS-1:0] q,
                                                       input logic [SUM_BITS-1:0]     sum,
                                                       input logic [COUNT_BITS-1:0]   count,
                                                       input logic [DATA_BITS-1:0]    worst);
      if (count == '0 || sum == '0) begin
         return worst;
      end
      if (q[DIV_NUM_BITS-1:DATA_BITS] != '0) begin
         return U32_MAX;
      end
      return q[DATA_BITS-1:0];
   endfunction

   function automatic logic [DATA_BITS-1:0] sat_scale(input logic [DIV_NUM_BITS-1:0] q,
                                                      input logic                    neg);
      logic over_neg;
      over_neg = (q[DIV_NUM_BITS-1:DATA_BITS] != '0) ||
                 (q[DATA_BITS-1] && (q[DATA_BITS-2:0] != '0));
      if (neg) begin
         return over_neg ? S32_MIN : (~q[DATA_BITS-1:0] + DATA_BITS'(1));
      end
      return (q[DIV_NUM_BITS-1:DATA_BITS-1] != '0) ? S32_MAX : q[DATA_BITS-1:0];
   endfunction

   function automatic logic [DATA_BITS-1:0] sat_agree(input logic [AGREE_BITS-1:0] t);
      if ((&t[AGREE_BITS-1:DATA_BITS-1]) || !(|t[AGREE_BITS-1:DATA_BITS-1])) begin
         return t[DATA_BITS-1:0];
      end
      return t[AGREE_BITS-1] ? S32_MIN : S32_MAX;
   endfunction

endpackage

// ===== hw/rtl/step_scale_calibrator.sv =====
// Sensor, rejected and first reference items go from ST_ACCUM straight to ST_FINISH.
// Other reference items run serial divides: the reference mean check ends after one, the
// sensor check after two, and a new scale takes all four (two means, scale, agreement).
// One item in flight: a new item is taken only in ST_IDLE, once its result is registered.
// Reset (synchronous): sums and counts clear, registers take their defaults, scale loads.
// ----------------------------------------------------------------------------
// step_scale_calibrator
// Learns reference units per sensor step from running sums of both streams,
// in signed Q16.16, with a register port for limits and the initial scale.
// ----------------------------------------------------------------------------
module step_scale_calibrator import ssc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic signed [DATA_BITS-1:0] req_amount,
   input  logic [DATA_BITS-1:0]        req_item_accuracy,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DATA_BITS-1:0] rsp_scale_out,
   output logic [DATA_BITS-1:0]        rsp_scale_accuracy,
   output logic signed [DATA_BITS-1:0] rsp_agreement_percent,
   output logic                        rsp_updated,
   output logic                        rsp_divide_fault,

   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [DATA_BITS-1:0]        csr_pwdata,
   output logic [DATA_BITS-1:0]        csr_prdata,
   output logic                        csr_pready
);

   logic [DATA_BITS-1:0] reject_level_ff,   reject_level_in;
   logic [DATA_BITS-1:0] initial_scale_ff,  initial_scale_in;
   logic [DATA_BITS-1:0] worst_accuracy_ff, worst_accuracy_in;
   logic [DATA_BITS-1:0] scale_value_ff,    scale_value_in;
   logic [DATA_BITS-1:0] scale_acc_ff,      scale_acc_in;
   logic [DATA_BITS-1:0] agreement_ff,      agreement_in;

   logic                 rsp_valid_ff,      rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_scale_ff,      rsp_scale_in;
   logic [DATA_BITS-1:0] rsp_acc_ff,        rsp_acc_in;
   logic [DATA_BITS-1:0] rsp_agree_ff,      rsp_agree_in;
   logic                 rsp_updated_ff,    rsp_updated_in;
   logic                 rsp_fault_ff,      rsp_fault_in;

   logic                 csr_write;
   logic [1:0]           csr_index;
   logic                 out_free;
   cfg_type              cfg;
   cal_result_type       result;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   assign cfg.reject_level   = reject_level_ff;
   assign cfg.worst_accuracy = worst_accuracy_ff;

   // the output register frees up when it is empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   ssc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ssc_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_amount        (req_amount),
      .req_item_accuracy (req_item_accuracy),
      .cfg               (cfg),
      .old_scale         (scale_value_ff),
      .out_free          (out_free),
      .result            (result),
      .div_req           (div_req),
      .div_rsp           (div_rsp)
   );

   always_comb begin
      case (csr_index)
         REG_REJECT_LEVEL:   csr_prdata = reject_level_ff;
         REG_INITIAL_SCALE:  csr_prdata = initial_scale_ff;
         REG_WORST_ACCURACY: csr_prdata = worst_accuracy_ff;
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      reject_level_in   = reject_level_ff;
      initial_scale_in  = initial_scale_ff;
      worst_accuracy_in = worst_accuracy_ff;
      scale_value_in    = scale_value_ff;
      scale_acc_in      = scale_acc_ff;
      agreement_in      = agreement_ff;

      if (result.done && result.updated) begin
         scale_value_in = result.scale;
         scale_acc_in   = result.accuracy;
         agreement_in   = result.agreement;
      end

      if (csr_write) begin
         case (csr_index)
            REG_REJECT_LEVEL: begin
               reject_level_in = csr_pwdata;
            end
            REG_INITIAL_SCALE: begin
               initial_scale_in = csr_pwdata;
               scale_value_in   = csr_pwdata;
            end
            REG_WORST_ACCURACY: begin
               worst_accuracy_in = csr_pwdata;
               scale_acc_in      = csr_pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_scale_in   = rsp_scale_ff;
      rsp_acc_in     = rsp_acc_ff;
      rsp_agree_in   = rsp_agree_ff;
      rsp_updated_in = rsp_updated_ff;
      rsp_fault_in   = rsp_fault_ff;
      if (result.done) begin
         rsp_valid_in   = 1'b1;
         rsp_scale_in   = result.updated ? result.scale     : scale_value_ff;
         rsp_acc_in     = result.updated ? result.accuracy  : scale_acc_ff;
         rsp_agree_in   = result.updated ? result.agreement : agreement_ff;
         rsp_updated_in = result.updated;
         rsp_fault_in   = result.fault;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_level_ff   <= REJECT_LEVEL_RESET;
         initial_scale_ff  <= INITIAL_SCALE_RESET;
         worst_accuracy_ff <= WORST_ACCURACY_RESET;
         scale_value_ff    <= INITIAL_SCALE_RESET;
         scale_acc_ff      <= WORST_ACCURACY_RESET;
         agreement_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         reject_level_ff   <= reject_level_in;
         initial_scale_ff  <= initial_scale_in;
         worst_accuracy_ff <= worst_accuracy_in;
         scale_value_ff    <= scale_value_in;
         scale_acc_ff      <= scale_acc_in;
         agreement_ff      <= agreement_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_scale_ff   <= rsp_scale_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_agree_ff   <= rsp_agree_in;
      rsp_updated_ff <= rsp_updated_in;
      rsp_fault_ff   <= rsp_fault_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_scale_out         = rsp_scale_ff;
   assign rsp_scale_accuracy    = rsp_acc_ff;
   assign rsp_agreement_percent = rsp_agree_ff;
   assign rsp_updated           = rsp_updated_ff;
   assign rsp_divide_fault      = rsp_fault_ff;

endmodule

// ===== hw/rtl/ssc_divider.sv =====
// ----------------------------------------------------------------------------
// ssc_divider
// Restoring unsigned divider, one quotient bit per cycle. The numerator
// arrives left-aligned so that only its top "steps" bits are worked through.
// ----------------------------------------------------------------------------
module ssc_divider import ssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                     busy_ff,  busy_in;
   logic                     done_ff,  done_in;
   logic [DIV_STEP_BITS-1:0] cnt_ff,   cnt_in;
   logic [DIV_DEN_BITS-1:0]  rem_ff,   rem_in;
   logic [DIV_DEN_BITS-1:0]  den_ff,   den_in;
   logic [DIV_NUM_BITS-1:0]  quo_ff,   quo_in;

   logic [DIV_DEN_BITS:0]    rem_shift;
   logic [DIV_DEN_BITS:0]    rem_sub;
   logic                     fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_sub   = rem_shift - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = '0;
         den_in  = req.denom;
         quo_in  = req.numer;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DIV_DEN_BITS-1:0] : rem_shift[DIV_DEN_BITS-1:0];
         quo_in = {quo_ff[DIV_NUM_BITS-2:0], fits};
         cnt_in = cnt_ff - DIV_STEP_BITS'(1);
         if (cnt_ff == DIV_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/ssc_engine.sv =====
// ----------------------------------------------------------------------------
// ssc_engine
// Sequencer and datapath: running sums, mean checks, scale and agreement,
// all divisions routed through the shared divider.
// ----------------------------------------------------------------------------
module ssc_engine import ssc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [DATA_BITS-1:0]  req_amount,
   input  logic [DATA_BITS-1:0]  req_item_accuracy,
   input  cfg_type               cfg,
   input  logic [DATA_BITS-1:0]  old_scale,
   input  logic                  out_free,
   output cal_result_type        result,
   output div_req_type           div_req,
   input  div_rsp_type           div_rsp
);

   state_type state_ff, state_in;

   logic                      in_mode_ff,        in_mode_in;
   logic [DATA_BITS-1:0]      in_amount_ff,      in_amount_in;
   logic [DATA_BITS-1:0]      in_acc_ff,         in_acc_in;

   logic [SUM_BITS-1:0]       ref_sum_ff,        ref_sum_in;
   logic [SUM_BITS-1:0]       ref_acc_sum_ff,    ref_acc_sum_in;
   logic [COUNT_BITS-1:0]     ref_count_ff,      ref_count_in;
   logic [SUM_BITS-1:0]       sensor_sum_ff,     sensor_sum_in;
   logic [SUM_BITS-1:0]       sensor_acc_sum_ff, sensor_acc_sum_in;
   logic [COUNT_BITS-1:0]     sensor_count_ff,   sensor_count_in;

   logic [DATA_BITS-1:0]      racc_ff,           racc_in;
   logic [DATA_BITS-1:0]      sacc_ff,           sacc_in;
   logic [DATA_BITS-1:0]      new_scale_ff,      new_scale_in;
   logic [AGREE_NUM_BITS-1:0] agree_num_ff,      agree_num_in;
   logic [DATA_BITS-1:0]      agree_den_ff,      agree_den_in;
   logic                      agree_neg_ff,      agree_neg_in;
   logic [DATA_BITS-1:0]      agree_ff,          agree_in;
   logic                      updated_ff,        updated_in;
   logic                      fault_ff,          fault_in;

   logic                      ref_ok;
   logic                      sensor_ok;
   logic                      reject;
   logic                      old_gt;
   logic [DATA_BITS-1:0]      d_val;
   logic [DATA_BITS:0]        diff_val;
   logic [AGREE_BITS-1:0]     agree_t;

   assign reject    = in_acc_ff > cfg.reject_level;
   assign ref_ok    = mag_sum(ref_sum_ff) >
                      {{(SUM_BITS-PROD_BITS){1'b0}}, times_hundred(racc_ff)};
   assign sensor_ok = mag_sum(sensor_sum_ff) >
                      {{(SUM_BITS-PROD_BITS){1'b0}}, times_hundred(sacc_ff)};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (in_mode_ff == MODE_SENSOR || reject || ref_count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_RACC_DIV;
            end
         end
         ST_RACC_DIV: begin
            if (div_rsp.done) state_in = ST_RACC_CHK;
         end
         ST_RACC_CHK: begin
            state_in = ref_ok ? ST_SACC_DIV : ST_FINISH;
         end
         ST_SACC_DIV: begin
            if (div_rsp.done) state_in = ST_SACC_CHK;
         end
         ST_SACC_CHK: begin
            state_in = sensor_ok ? ST_SCALE_DIV : ST_FINISH;
         end
         ST_SCALE_DIV: begin
            if (div_rsp.done) state_in = ST_AGREE_PREP;
         end
         ST_AGREE_PREP: begin
            state_in = ST_AGREE_DIV;
         end
         ST_AGREE_DIV: begin
            if (div_rsp.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = state_ff == ST_IDLE;
      div_req.start = 1'b0;
      div_req.numer = {ref_acc_sum_ff, {(DIV_NUM_BITS-SUM_BITS){1'b0}}};
      div_req.denom = {{(DIV_DEN_BITS-COUNT_BITS){1'b0}}, ref_count_ff};
      div_req.steps = MEAN_STEPS;
      case (state_ff)
         ST_RACC_DIV: begin
            div_req.start = !div_rsp.busy && !div_rsp.done;
         end
         ST_SACC_DIV: begin
            div_req.start = !div_rsp.busy && !div_rsp.done;
            div_req.numer = {sensor_acc_sum_ff, {(DIV_NUM_BITS-SUM_BITS){1'b0}}};
            div_req.denom = {{(DIV_DEN_BITS-COUNT_BITS){1'b0}}, sensor_count_ff};
         end
         ST_SCALE_DIV: begin
            div_req.start = !div_rsp.busy && !div_rsp.done;
            div_req.numer = {mag_sum(ref_sum_ff), {FRAC_BITS{1'b0}}};
            div_req.denom = mag_sum(sensor_sum_ff);
            div_req.steps = SCALE_STEPS;
         end
         ST_AGREE_DIV: begin
            div_req.start = !div_rsp.busy && !div_rsp.done;
            div_req.numer = {agree_num_ff, {(DIV_NUM_BITS-AGREE_NUM_BITS){1'b0}}};
            div_req.denom = {{(DIV_DEN_BITS-DATA_BITS){1'b0}}, agree_den_ff};
            div_req.steps = AGREE_STEPS;
         end
         default: begin
         end
      endcase

      result.done      = (state_ff == ST_FINISH) && out_free;
      result.updated   = updated_ff;
      result.fault     = fault_ff;
      result.scale     = new_scale_ff;
      result.accuracy  = racc_ff;
      result.agreement = agree_ff;
   end

   // datapath
   always_comb begin
      old_gt   = $signed(old_scale) > $signed(new_scale_ff);
      d_val    = old_gt ? old_scale : new_scale_ff;
      diff_val = old_gt ? ({old_scale[DATA_BITS-1], old_scale} -
                           {new_scale_ff[DATA_BITS-1], new_scale_ff})
                        : ({new_scale_ff[DATA_BITS-1], new_scale_ff} -
                           {old_scale[DATA_BITS-1], old_scale});
      agree_t  = agree_neg_ff ?
                 HUNDRED_Q + {2'b00, div_rsp.quotient[AGREE_NUM_BITS-1:0]} :
                 HUNDRED_Q - {2'b00, div_rsp.quotient[AGREE_NUM_BITS-1:0]};

      in_mode_in        = in_mode_ff;
      in_amount_in      = in_amount_ff;
      in_acc_in         = in_acc_ff;
      ref_sum_in        = ref_sum_ff;
      ref_acc_sum_in    = ref_acc_sum_ff;
      ref_count_in      = ref_count_ff;
      sensor_sum_in     = sensor_sum_ff;
      sensor_acc_sum_in = sensor_acc_sum_ff;
      sensor_count_in   = sensor_count_ff;
      racc_in           = racc_ff;
      sacc_in           = sacc_ff;
      new_scale_in      = new_scale_ff;
      agree_num_in      = agree_num_ff;
      agree_den_in      = agree_den_ff;
      agree_neg_in      = agree_neg_ff;
      agree_in          = agree_ff;
      updated_in        = updated_ff;
      fault_in          = fault_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_mode_in   = req_mode;
               in_amount_in = req_amount;
               in_acc_in    = req_item_accuracy;
            end
         end
         ST_ACCUM: begin
            updated_in = 1'b0;
            fault_in   = 1'b0;
            if (in_mode_ff == MODE_SENSOR) begin
               sensor_sum_in     = sat_add_sum(sensor_sum_ff, in_amount_ff);
               sensor_acc_sum_in = sat_add_usum(sensor_acc_sum_ff, in_acc_ff);
               sensor_count_in   = inc_count(sensor_count_ff);
            end else if (reject) begin
               ref_sum_in        = '0;
               ref_acc_sum_in    = '0;
               ref_count_in      = '0;
               sensor_sum_in     = '0;
               sensor_acc_sum_in = '0;
               sensor_count_in   = '0;
            end else if (ref_count_ff == '0) begin
               ref_sum_in     = {{(SUM_BITS-DATA_BITS){in_amount_ff[DATA_BITS-1]}},
                                 in_amount_ff};
               ref_acc_sum_in = {{(SUM_BITS-DATA_BITS){1'b0}}, in_acc_ff};
               ref_count_in   = COUNT_BITS'(1);
            end else begin
               ref_sum_in     = sat_add_sum(ref_sum_ff, in_amount_ff);
               ref_acc_sum_in = sat_add_usum(ref_acc_sum_ff, in_acc_ff);
               ref_count_in   = inc_count(ref_count_ff);
            end
         end
         ST_RACC_DIV: begin
            if (div_rsp.done) begin
               racc_in = mean_value(div_rsp.quotient, ref_acc_sum_ff, ref_count_ff,
                                    cfg.worst_accuracy);
            end
         end
         ST_SACC_DIV: begin
            if (div_rsp.done) begin
               sacc_in = mean_value(div_rsp.quotient, sensor_acc_sum_ff, sensor_count_ff,
                                    cfg.worst_accuracy);
            end
         end
         ST_SCALE_DIV: begin
            if (div_rsp.done) begin
               if (sensor_sum_ff == '0) begin
                  new_scale_in = '0;
                  fault_in     = 1'b1;
               end else begin
                  new_scale_in = sat_scale(div_rsp.quotient,
                                           ref_sum_ff[SUM_BITS-1] ^ sensor_sum_ff[SUM_BITS-1]);
               end
            end
         end
         ST_AGREE_PREP: begin
            agree_num_in = {times_hundred(diff_val[DATA_BITS-1:0]), {FRAC_BITS{1'b0}}};
            agree_den_in = d_val[DATA_BITS-1] ? (~d_val + DATA_BITS'(1)) : d_val;
            agree_neg_in = d_val[DATA_BITS-1];
            if (d_val == '0) fault_in = 1'b1;
         end
         ST_AGREE_DIV: begin
            if (div_rsp.done) begin
               // a zero divisor stands for a zero quotient
               agree_in   = (agree_den_ff == '0) ? HUNDRED_Q[DATA_BITS-1:0]
                                                 : sat_agree(agree_t);
               updated_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         ref_sum_ff        <= '0;
         ref_acc_sum_ff    <= '0;
         ref_count_ff      <= '0;
         sensor_sum_ff     <= '0;
         sensor_acc_sum_ff <= '0;
         sensor_count_ff   <= '0;
      end else begin
         state_ff          <= state_in;
         ref_sum_ff        <= ref_sum_in;
         ref_acc_sum_ff    <= ref_acc_sum_in;
         ref_count_ff      <= ref_count_in;
         sensor_sum_ff     <= sensor_sum_in;
         sensor_acc_sum_ff <= sensor_acc_sum_in;
         sensor_count_ff   <= sensor_count_in;
      end
      in_mode_ff   <= in_mode_in;
      in_amount_ff <= in_amount_in;
      in_acc_ff    <= in_acc_in;
      racc_ff      <= racc_in;
      sacc_ff      <= sacc_in;
      new_scale_ff <= new_scale_in;
      agree_num_ff <= agree_num_in;
      agree_den_ff <= agree_den_in;
      agree_neg_ff <= agree_neg_in;
      agree_ff     <= agree_in;
      updated_ff   <= updated_in;
      fault_ff     <= fault_in;
   end

endmodule
